### hdl/wne_pkg.sv
// ----------------------------------------------------------------------------
// wne_pkg
// Shared constants, widths and the queue item type for the 3D wavelet noise
// evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wne_pkg;

    localparam int DEF_TILE_SIZE = 32;
    localparam int POS_W         = 32;
    localparam int ADDR_W        = 15;
    localparam int COEF_W        = 16;
    localparam int W_W           = 16;
    localparam int MID_W         = 18;
    localparam int IDX_MAX_W     = 7;
    localparam int HALF_M1       = 32767;
    localparam int ONE_Q16       = 65536;
    localparam int ACC_W         = 50;
    localparam int PROD_W        = 49;
    localparam int RES_W         = ACC_W - 32;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    typedef logic [2:0][W_W-1:0] wne_wts_t;

    typedef struct packed {
        logic                 eval;
        logic [ADDR_W-1:0]    addr;
        logic [COEF_W-1:0]    value;
        logic [IDX_MAX_W-1:0] bx;
        logic [IDX_MAX_W-1:0] by;
        logic [IDX_MAX_W-1:0] bz;
        wne_wts_t             wx;
        wne_wts_t             wy;
        wne_wts_t             wz;
    } wne_item_t;

endpackage

`default_nettype wire

### hdl/wavelet_noise_evaluate_3d.sv
// An evaluate passes through the front (reciprocal index reduction) and the
// back (27 single-port tile reads and a 4-stage multiply-accumulate) to the
// output register. The back takes one evaluate at a time, as all 27 reads
// share the tile memory port; one write per cycle while in_stall is low.
// Reset clears all control state; the tile contents are undefined until
// written.
// ----------------------------------------------------------------------------
// wavelet_noise_evaluate_3d
// Quadratic B-spline wavelet noise over a periodic cubic coefficient tile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wavelet_noise_evaluate_3d
    import wne_pkg::*;
#(
    parameter int TILE_SIZE = DEF_TILE_SIZE
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     action,
    input  wire logic [ADDR_W-1:0]        tile_address,
    input  wire logic signed [COEF_W-1:0] tile_value,
    input  wire logic signed [POS_W-1:0]  pos_x,
    input  wire logic signed [POS_W-1:0]  pos_y,
    input  wire logic signed [POS_W-1:0]  pos_z,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [COEF_W-1:0]      noise_value
);

    logic      push;
    wne_item_t push_item;
    logic      q_full;
    logic      q_empty;
    logic      pop;
    wne_item_t head;

    wne_front #(.TILE_SIZE(TILE_SIZE)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .tile_address (tile_address),
        .tile_value   (tile_value),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .push         (push),
        .push_item    (push_item),
        .q_full       (q_full)
    );

    wne_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty)
    );

    wne_back #(.TILE_SIZE(TILE_SIZE)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (q_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .noise_value (noise_value)
    );

endmodule

`default_nettype wire

### hdl/wne_front.sv
// ----------------------------------------------------------------------------
// wne_front
// Accepts transactions, passes writes on, and for evaluates derives the
// per-axis B-spline weights and the wrapped base index (reciprocal
// reduction).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wne_front
    import wne_pkg::*;
#(
    parameter int TILE_SIZE = DEF_TILE_SIZE
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     action,
    input  wire logic [ADDR_W-1:0]        tile_address,
    input  wire logic signed [COEF_W-1:0] tile_value,
    input  wire logic signed [POS_W-1:0]  pos_x,
    input  wire logic signed [POS_W-1:0]  pos_y,
    input  wire logic signed [POS_W-1:0]  pos_z,
    output logic                          push,
    output wne_item_t                     push_item,
    input  wire logic                     q_full
);

    localparam int CNT_W = 1;
    localparam int RCP   = (1 << MID_W) / TILE_SIZE;
    localparam int OFS   = TILE_SIZE * ((HALF_M1 + 2) / TILE_SIZE + 1);

    logic                 busy_reg, busy_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 accept;
    logic                 done;
    logic [POS_W-1:0]     pos [3];
    logic [MID_W-1:0]     sh_reg  [3];
    logic [MID_W-1:0]     quo_reg [3];
    wne_wts_t             w_reg   [3];
    logic [IDX_MAX_W-1:0] base    [3];

    assign pos[0] = pos_x;
    assign pos[1] = pos_y;
    assign pos[2] = pos_z;

    assign in_stall = busy_reg || q_full;
    assign accept   = in_valid && !in_stall;
    assign done     = busy_reg && (cnt_reg == CNT_W'(1));
    assign push     = (accept && (action == ACT_WRITE)) || (done && !q_full);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (accept && (action == ACT_EVAL))
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg && !done)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (done && !q_full)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        logic [POS_W+1:0]   s;
        logic [MID_W-1:0]   m1;
        logic [W_W-1:0]     t;
        logic [W_W:0]       u;
        logic [2*W_W-1:0]   sq0;
        logic [2*W_W+1:0]   sq2;
        logic [W_W-1:0]     w0;
        logic [W_W-1:0]     w2;
        logic [W_W-1:0]     w1;
        logic [2*MID_W-1:0] qprod;
        logic [MID_W-1:0]   rem0;
        logic [MID_W-1:0]   fin;

        always_comb
        begin
            s     = {{2{pos[a][POS_W-1]}}, pos[a]} + (POS_W+2)'(HALF_M1);
            m1    = s[POS_W+1:W_W] - MID_W'(1);
            t     = W_W'(HALF_M1 + 1) - pos[a][W_W-1:0];
            u     = (W_W+1)'(ONE_Q16) - {1'b0, t};
            sq0   = t * t;
            sq2   = u * u;
            w0    = {1'b0, sq0[2*W_W-1:17]};
            w2    = sq2[2*W_W:17];
            w1    = W_W'((W_W+1)'(ONE_Q16) - {1'b0, w0} - {1'b0, w2});
            qprod = sh_reg[a] * MID_W'(RCP);
            rem0  = sh_reg[a] - quo_reg[a] * MID_W'(TILE_SIZE);
            if (rem0 >= MID_W'(TILE_SIZE))
                fin = rem0 - MID_W'(TILE_SIZE);
            else
                fin = rem0;
            base[a] = IDX_MAX_W'(fin);
        end

        always_ff @(posedge clk)
        begin
            if (accept && (action == ACT_EVAL))
            begin
                sh_reg[a] <= m1 + MID_W'(OFS);
                w_reg[a]  <= {w2, w1, w0};
            end
            else if (busy_reg && !done)
            begin
                quo_reg[a] <= qprod[2*MID_W-1:MID_W];
            end
        end
    end

    always_comb
    begin
        push_item.eval  = busy_reg;
        push_item.addr  = tile_address;
        push_item.value = tile_value;
        push_item.bx    = base[0];
        push_item.by    = base[1];
        push_item.bz    = base[2];
        push_item.wx    = w_reg[0];
        push_item.wy    = w_reg[1];
        push_item.wz    = w_reg[2];
    end

endmodule

`default_nettype wire

### hdl/wne_queue.sv
// ----------------------------------------------------------------------------
// wne_queue
// Two-entry queue of classified transactions between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wne_queue
    import wne_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire wne_item_t push_item,
    output logic           full,
    input  wire logic      pop,
    output wne_item_t      head,
    output logic           empty
);

    wne_item_t  ent_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = ent_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? !wp_reg : wp_reg;
        rp_next  = pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wp_reg] <= push_item;
    end

endmodule

`default_nettype wire

### hdl/wne_back.sv
// ----------------------------------------------------------------------------
// wne_back
// Holds the tile memory, performs writes and walks the 27 taps of an
// evaluate through a multiply-accumulate pipeline into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wne_back
    import wne_pkg::*;
#(
    parameter int TILE_SIZE = DEF_TILE_SIZE
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wne_item_t         head,
    input  wire logic              empty,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic signed [COEF_W-1:0] noise_value
);

    localparam int IW    = $clog2(TILE_SIZE);
    localparam int DEPTH = TILE_SIZE * TILE_SIZE * TILE_SIZE;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [COEF_W-1:0] mem [DEPTH];

    logic [1:0]      state_reg, state_next;
    wne_item_t       cur_reg;
    logic [1:0]      i_reg, j_reg, k_reg;
    logic [IW-1:0]   cx_reg, cy_reg, cz_reg;
    logic            start;
    logic            do_write;
    logic            issue;
    logic            last0;
    logic [AW-1:0]   raddr;
    logic [AW-1:0]   mem_addr;

    logic                   v1_reg, v2_reg, v3_reg;
    logic                   l1_reg, l2_reg, l3_reg;
    logic [2*W_W-1:0]       pxy_reg;
    logic [W_W-1:0]         wz1_reg;
    logic [COEF_W-1:0]      rd_reg;
    logic [2*W_W-1:0]       pw_reg;
    logic [COEF_W-1:0]      coef2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [RES_W-1:0]  res;
    logic signed [COEF_W-1:0] sat;
    logic [3*W_W-1:0]       pw_full;
    logic                   out_valid_reg;
    logic [COEF_W-1:0]      noise_reg;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v);
        if (v == IW'(TILE_SIZE - 1))
            return '0;
        return v + 1'b1;
    endfunction

    assign do_write = (state_reg == ST_IDLE) && !empty && !head.eval;
    assign start    = (state_reg == ST_IDLE) && !empty && head.eval && !out_valid_reg;
    assign pop      = do_write || start;
    assign issue    = (state_reg == ST_RUN);
    assign last0    = (i_reg == 2'd2) && (j_reg == 2'd2) && (k_reg == 2'd2);

    assign raddr    = AW'(cx_reg) + AW'(cy_reg) * AW'(TILE_SIZE)
                    + AW'(cz_reg) * AW'(TILE_SIZE * TILE_SIZE);
    assign mem_addr = do_write ? AW'(head.addr) : raddr;

    always_ff @(posedge clk)
    begin
        if (do_write && (32'(head.addr) < 32'(DEPTH)))
            mem[mem_addr] <= head.value;
        rd_reg <= mem[mem_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start) state_next = ST_RUN;
            ST_RUN:   if (last0) state_next = ST_DRAIN;
            ST_DRAIN: if (v3_reg && l3_reg) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cur_reg <= head;
            i_reg   <= '0;
            j_reg   <= '0;
            k_reg   <= '0;
            cx_reg  <= head.bx[IW-1:0];
            cy_reg  <= head.by[IW-1:0];
            cz_reg  <= head.bz[IW-1:0];
        end
        else if (issue)
        begin
            if (i_reg == 2'd2)
            begin
                i_reg  <= '0;
                cx_reg <= cur_reg.bx[IW-1:0];
                if (j_reg == 2'd2)
                begin
                    j_reg  <= '0;
                    cy_reg <= cur_reg.by[IW-1:0];
                    k_reg  <= k_reg + 1'b1;
                    cz_reg <= wrap_inc(cz_reg);
                end
                else
                begin
                    j_reg  <= j_reg + 1'b1;
                    cy_reg <= wrap_inc(cy_reg);
                end
            end
            else
            begin
                i_reg  <= i_reg + 1'b1;
                cx_reg <= wrap_inc(cx_reg);
            end
        end
    end

    assign pw_full = pxy_reg * wz1_reg;

    always_ff @(posedge clk)
    begin
        l1_reg    <= last0;
        pxy_reg   <= cur_reg.wx[i_reg] * cur_reg.wy[j_reg];
        wz1_reg   <= cur_reg.wz[k_reg];
        l2_reg    <= l1_reg;
        pw_reg    <= pw_full[3*W_W-1:W_W];
        coef2_reg <= rd_reg;
        l3_reg    <= l2_reg;
        prod_reg  <= $signed({1'b0, pw_reg}) * $signed(coef2_reg);
    end

    always_comb
    begin
        acc_next = acc_reg + ACC_W'(prod_reg);
        rnd      = acc_next + (ACC_W'(1) <<< 31);
        res      = rnd[ACC_W-1:32];
        if (res > RES_W'(32767))
            sat = 16'sh7fff;
        else if (res < -RES_W'(32768))
            sat = 16'sh8000;
        else
            sat = res[COEF_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (start)
            acc_reg <= '0;
        else if (v3_reg)
            acc_reg <= acc_next;
        if (v3_reg && l3_reg)
            noise_reg <= sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (v3_reg && l3_reg)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = noise_reg;

endmodule

`default_nettype wire

### hdl/wne_checker.sv
// ----------------------------------------------------------------------------
// wne_checker
// Port-level checks of the wavelet noise evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wne_checker
    import wne_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_valid,
    input wire logic                     in_stall,
    input wire logic                     action,
    input wire logic [ADDR_W-1:0]        tile_address,
    input wire logic signed [COEF_W-1:0] tile_value,
    input wire logic signed [POS_W-1:0]  pos_x,
    input wire logic signed [POS_W-1:0]  pos_y,
    input wire logic signed [POS_W-1:0]  pos_z,
    input wire logic                     out_valid,
    input wire logic                     out_stall,
    input wire logic signed [COEF_W-1:0] noise_value
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(noise_value)))
        else $error("result dropped or changed while stalled");

    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (action == ACT_EVAL))
        |=> in_stall ##1 in_stall)
        else $error("front accepted a transaction during index reduction");

    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present right after reset");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(!rst_n) && rst_n) |=> !out_valid)
        else $error("result without an evaluate");

endmodule

bind wavelet_noise_evaluate_3d wne_checker u_wne_checker (.*);

`default_nettype wire
